[rtl/msd_pkg.sv]
// Package for the multi-axis step distributor: commands, states, beat and lane types.
package msd_pkg;

  localparam int NUM_AXES_DEF     = 4;
  localparam int MAX_SUBSTEPS_DEF = 16;
  localparam int RESULT_CAP       = 16;
  localparam int AXIS_FIELD_W     = 6;
  localparam int STEPS_W          = 24;
  localparam int ACC_W            = 27;
  localparam int POS_W            = 32;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_DELTA = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_ZERO  = 3'd4
  } msd_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } msd_state_t;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [STEPS_W-1:0]      segment_steps;
    logic [AXIS_FIELD_W-1:0] direction_bits;
    logic [2:0]              axis_select;
    logic [STEPS_W-1:0]      axis_steps;
    logic [4:0]              substeps;
  } msd_in_t;

  typedef struct packed {
    logic [AXIS_FIELD_W-1:0] step_mask;
    logic [AXIS_FIELD_W-1:0] dir_mask;
    logic                    last;
    logic                    segment_done;
    logic signed [POS_W-1:0] axis_position;
  } msd_out_t;

  // Per-lane control from the sequencer
  typedef struct packed {
    logic               start;
    logic               load_delta;
    logic               step_en;
    logic               zero_pos;
    logic               dir;
    logic [STEPS_W-1:0] segment_steps;
    logic [STEPS_W-1:0] axis_steps;
    logic [STEPS_W-1:0] total;
  } msd_lane_ctrl_t;

endpackage

[rtl/msd_axis_lane.sv]
// One axis: doubled delta, saturating error accumulator and position counter.
module msd_axis_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  msd_pkg::msd_lane_ctrl_t       ctrl,
  output logic                          step,
  output logic [msd_pkg::POS_W-1:0]     position
);
  import msd_pkg::*;

  logic [STEPS_W:0]         delta;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  sat;
  logic signed [ACC_W-1:0]  acc_next;

  always_comb begin
    sum = {acc[ACC_W-1], acc} + $signed({3'b000, delta});
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat = sum[ACC_W-1:0];
    end
    step = !sat[ACC_W-1];
    // stepping pulls the accumulator back by twice the segment total
    acc_next = step ? sat - $signed({2'b00, ctrl.total, 1'b0}) : sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delta    <= '0;
      acc      <= '0;
      position <= '0;
    end else begin
      if (ctrl.load_delta) begin
        delta <= {ctrl.axis_steps, 1'b0};
      end
      if (ctrl.start) begin
        acc <= $signed(ACC_W'(0) - {3'b000, ctrl.segment_steps});
      end else if (ctrl.step_en) begin
        acc <= acc_next;
      end
      if (ctrl.zero_pos) begin
        position <= '0;
      end else if (ctrl.step_en && step) begin
        position <= position + (ctrl.dir ? POS_W'(1) : {POS_W{1'b1}});
      end
    end
  end

endmodule

[rtl/multi_axis_step_distributor_unit.sv]
// Top level: command decode, substep sequencer and axis lanes.
//
// Usage: commands arrive as beats on the in channel (valid/stall) and results
// leave on the out channel (valid/stall), both held stable while stalled.
// Start segment, set axis delta and zero positions give no beat. Read position
// gives one beat in the cycle after acceptance. A tick runs min(pending steps,
// substeps) substeps, zero substeps counting as one and capped at SUB_CAP, one
// per cycle while the output is not stalled, all axes updated in parallel by
// the lanes, giving one beat per substep; the first beat passes the state
// register, then the output register. A tick with nothing pending gives no
// beat. The substep sequencer is the limit: the block takes no new beat while
// a tick runs, or while a finished beat sits stalled in the output register.
// When the receiver stalls, the sequencer holds and resumes when the output
// register is taken. Synchronous reset clears segment state, deltas,
// accumulators and positions; the block is ready on the next cycle.
module multi_axis_step_distributor_unit #(
  parameter int NUM_AXES     = msd_pkg::NUM_AXES_DEF,
  parameter int MAX_SUBSTEPS = msd_pkg::MAX_SUBSTEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  msd_pkg::msd_in_t  in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output msd_pkg::msd_out_t out_beat
);
  import msd_pkg::*;

  localparam int SUB_CAP = (MAX_SUBSTEPS < RESULT_CAP) ? MAX_SUBSTEPS : RESULT_CAP;
  localparam int CNT_W   = $clog2(SUB_CAP + 1);
  localparam logic [AXIS_FIELD_W-1:0] DIR_MASK =
    AXIS_FIELD_W'((7'd1 << NUM_AXES) - 7'd1);

  msd_state_t state, state_next;

  logic [STEPS_W-1:0]      total;
  logic [STEPS_W-1:0]      taken;
  logic                    active;
  logic [AXIS_FIELD_W-1:0] dir_reg;
  logic [CNT_W-1:0]        count;

  logic                    out_free;
  logic                    accept;
  logic                    has_pending;
  logic [STEPS_W-1:0]      pending;
  logic [4:0]              sub_eff;
  logic [4:0]              n_val;
  logic                    step_go;
  logic [STEPS_W-1:0]      taken_inc;
  logic                    done;
  logic                    last_sub;

  msd_lane_ctrl_t          lane_ctrl [NUM_AXES];
  logic [NUM_AXES-1:0]     lane_step;
  logic [POS_W-1:0]        lane_pos [NUM_AXES];
  logic [AXIS_FIELD_W-1:0] mask_all;
  logic [POS_W-1:0]        pos_sel;

  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != ST_IDLE) || !out_free;
  assign accept      = in_valid && !in_stall;
  assign pending     = total - taken;
  assign has_pending = active && (taken < total);
  assign taken_inc   = taken + STEPS_W'(1);
  assign done        = (taken_inc == total);
  assign last_sub    = (count == CNT_W'(1));

  always_comb begin
    if (in_beat.substeps == 5'd0) begin
      sub_eff = 5'd1;
    end else if (in_beat.substeps > 5'(SUB_CAP)) begin
      sub_eff = 5'(SUB_CAP);
    end else begin
      sub_eff = in_beat.substeps;
    end
    n_val = (pending < {19'd0, sub_eff}) ? pending[4:0] : sub_eff;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_beat.cmd == CMD_TICK && has_pending) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_go && (last_sub || done)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    step_go = 1'b0;
    unique case (state)
      ST_IDLE: step_go = 1'b0;
      ST_RUN:  step_go = out_free;
      default: step_go = 1'b0;
    endcase
    for (int i = 0; i < NUM_AXES; i++) begin
      lane_ctrl[i].start         = accept && (in_beat.cmd == CMD_START);
      lane_ctrl[i].load_delta    = accept && (in_beat.cmd == CMD_DELTA) &&
                                   (in_beat.axis_select == 3'(i));
      lane_ctrl[i].step_en       = step_go;
      lane_ctrl[i].zero_pos      = accept && (in_beat.cmd == CMD_ZERO);
      lane_ctrl[i].dir           = dir_reg[i];
      lane_ctrl[i].segment_steps = in_beat.segment_steps;
      lane_ctrl[i].axis_steps    = in_beat.axis_steps;
      lane_ctrl[i].total         = total;
    end
  end

  always_comb begin
    mask_all = '0;
    pos_sel  = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      mask_all[i] = lane_step[i];
      if (in_beat.axis_select == 3'(i)) begin
        pos_sel = lane_pos[i];
      end
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    msd_axis_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lane_ctrl[g]),
      .step     (lane_step[g]),
      .position (lane_pos[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      total     <= '0;
      taken     <= '0;
      active    <= 1'b0;
      dir_reg   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_beat.cmd == CMD_START) begin
        total   <= in_beat.segment_steps;
        taken   <= '0;
        active  <= 1'b1;
        dir_reg <= in_beat.direction_bits & DIR_MASK;
      end
      if (accept && in_beat.cmd == CMD_TICK) begin
        count <= CNT_W'(n_val);
      end
      if (step_go) begin
        count <= count - CNT_W'(1);
        taken <= taken_inc;
        if (done) begin
          active <= 1'b0;
        end
      end
      if (step_go || (accept && in_beat.cmd == CMD_READ)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_beat.step_mask     <= mask_all;
      out_beat.dir_mask      <= dir_reg;
      out_beat.last          <= last_sub || done;
      out_beat.segment_done  <= done;
      out_beat.axis_position <= '0;
    end else if (accept && in_beat.cmd == CMD_READ) begin
      out_beat.step_mask     <= '0;
      out_beat.dir_mask      <= dir_reg;
      out_beat.last          <= 1'b1;
      out_beat.segment_done  <= !active;
      out_beat.axis_position <= $signed(pos_sel);
    end
  end

endmodule

[sim/multi_axis_step_distributor_unit_tb.sv]
// Self-checking testbench for the multi-axis Bresenham step distributor.
module multi_axis_step_distributor_unit_tb;
  import msd_pkg::*;

  localparam int N_AXES    = NUM_AXES_DEF;
  localparam int MAX_SUB   = MAX_SUBSTEPS_DEF;
  localparam int N_RANDOM  = 400;
  localparam int LONG_HOLD = 200;
  localparam int N_ROWS    = 26;

  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;

  localparam logic [AXIS_FIELD_W-1:0] AXIS_MASK = AXIS_FIELD_W'((1 << N_AXES) - 1);
  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));

  typedef struct packed {
    msd_in_t  beat;
    logic     typed;
    msd_out_t want;
  } cmd_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  msd_in_t  in_beat = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  msd_out_t out_beat;

  // segment state of the predictor
  bit [STEPS_W-1:0]      seg_total;
  bit [STEPS_W-1:0]      seg_taken;
  bit                    seg_active;
  bit [AXIS_FIELD_W-1:0] seg_dirs;
  int unsigned           dbl_delta [N_AXES];
  int                    err_acc   [N_AXES];
  bit [POS_W-1:0]        axis_pos  [N_AXES];

  msd_out_t    due_beats [$];
  msd_out_t    want_b;
  int unsigned err_cnt = 0;
  int unsigned cmds_done = 0;
  bit          idle_on = 1'b1;
  bit          hold_out = 1'b0;

  // beat fields, typed flag, then the expected beat for typed rows
  cmd_row_t cmd_table [N_ROWS] = '{
    {CMD_READ,   24'd0,       6'h00, 3'd0, 24'd0,       5'd0,  1'b1,
     6'h00, 6'h00, 1'b1, 1'b1, 32'd0},
    {CMD_TICK,   24'd0,       6'h00, 3'd0, 24'd0,       5'd1,  1'b0, 46'd0},
    {CMD_DELTA,  24'd0,       6'h00, 3'd0, 24'd10,      5'd0,  1'b0, 46'd0},
    {CMD_DELTA,  24'd0,       6'h00, 3'd1, 24'd5,       5'd0,  1'b0, 46'd0},
    {CMD_DELTA,  24'd0,       6'h00, 3'd2, 24'd0,       5'd0,  1'b0, 46'd0},
    {CMD_DELTA,  24'd0,       6'h00, 3'd3, 24'hFFFFFF,  5'd0,  1'b0, 46'd0},
    {CMD_DELTA,  24'd0,       6'h00, 3'd7, 24'd123,     5'd0,  1'b0, 46'd0},
    {CMD_START,  24'd10,      6'h3F, 3'd0, 24'd0,       5'd0,  1'b0, 46'd0},
    // zero substeps runs one
    {CMD_TICK,   24'd0,       6'h00, 3'd0, 24'd0,       5'd0,  1'b1,
     6'h0B, 6'h0F, 1'b1, 1'b0, 32'd0},
    {CMD_TICK,   24'd0,       6'h00, 3'd0, 24'd0,       5'd31, 1'b0, 46'd0},
    {CMD_TICK,   24'd0,       6'h00, 3'd0, 24'd0,       5'd1,  1'b0, 46'd0},
    {CMD_READ,   24'd0,       6'h00, 3'd0, 24'd0,       5'd0,  1'b1,
     6'h00, 6'h0F, 1'b1, 1'b1, 32'd10},
    {CMD_READ,   24'd0,       6'h00, 3'd6, 24'd0,       5'd0,  1'b1,
     6'h00, 6'h0F, 1'b1, 1'b1, 32'd0},
    // empty segment stays active
    {CMD_START,  24'd0,       6'h00, 3'd0, 24'd0,       5'd0,  1'b0, 46'd0},
    {CMD_TICK,   24'd0,       6'h00, 3'd0, 24'd0,       5'd5,  1'b0, 46'd0},
    {CMD_READ,   24'd0,       6'h00, 3'd1, 24'd0,       5'd0,  1'b0, 46'd0},
    {CMD_ZERO,   24'd0,       6'h00, 3'd0, 24'd0,       5'd0,  1'b0, 46'd0},
    {CMD_READ,   24'd0,       6'h00, 3'd3, 24'd0,       5'd0,  1'b1,
     6'h00, 6'h00, 1'b1, 1'b0, 32'd0},
    {CMD_START,  24'hFFFFFF,  6'h00, 3'd0, 24'd0,       5'd0,  1'b0, 46'd0},
    {CMD_TICK,   24'd0,       6'h00, 3'd0, 24'd0,       5'd16, 1'b0, 46'd0},
    {CMD_READ,   24'd0,       6'h00, 3'd0, 24'd0,       5'd0,  1'b0, 46'd0},
    {CMD_BAD_HI, 24'hFFFFFF,  6'h3F, 3'd7, 24'hFFFFFF,  5'h1F, 1'b0, 46'd0},
    // delta far above total drives the accumulator into saturation
    {CMD_START,  24'd3,       6'h05, 3'd0, 24'd0,       5'd0,  1'b0, 46'd0},
    {CMD_TICK,   24'd0,       6'h00, 3'd0, 24'd0,       5'd16, 1'b0, 46'd0},
    {CMD_START,  24'd1,       6'h05, 3'd0, 24'd0,       5'd0,  1'b0, 46'd0},
    {CMD_TICK,   24'd0,       6'h00, 3'd0, 24'd0,       5'd16, 1'b1,
     6'h0B, 6'h05, 1'b1, 1'b1, 32'd0}
  };

  multi_axis_step_distributor_unit #(
    .NUM_AXES     (N_AXES),
    .MAX_SUBSTEPS (MAX_SUB)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Updates the axis state for one command; queues its result beats when keep is set.
  task automatic distribute_cmd(input msd_in_t b, input bit keep);
    int       a;
    int       k;
    int       nsub;
    int       pend;
    longint   acc;
    msd_out_t r;
    r = '0;
    case (b.cmd)
      CMD_START: begin
        seg_total  = b.segment_steps;
        seg_taken  = '0;
        seg_active = 1'b1;
        seg_dirs   = b.direction_bits & AXIS_MASK;
        for (a = 0; a < N_AXES; a++) err_acc[a] = -int'(b.segment_steps);
      end
      CMD_DELTA: begin
        if (b.axis_select < N_AXES) dbl_delta[b.axis_select] = 32'({b.axis_steps, 1'b0});
      end
      CMD_TICK: begin
        if (seg_active && seg_taken < seg_total) begin
          nsub = (b.substeps == 0) ? 1 : int'(b.substeps);
          if (nsub > MAX_SUB) nsub = MAX_SUB;
          if (nsub > RESULT_CAP) nsub = RESULT_CAP;
          pend = int'(seg_total - seg_taken);
          if (pend < nsub) nsub = pend;
          for (k = 0; k < nsub; k++) begin
            r.step_mask = '0;
            for (a = 0; a < N_AXES; a++) begin
              acc = longint'(err_acc[a]) + longint'(dbl_delta[a]);
              if (acc > ACC_HI) acc = ACC_HI;
              if (acc < ACC_LO) acc = ACC_LO;
              if (acc >= 0) begin
                if (seg_dirs[a]) axis_pos[a] = axis_pos[a] + 1;
                else axis_pos[a] = axis_pos[a] - 1;
                acc = acc - 2 * longint'(seg_total);
                r.step_mask[a] = 1'b1;
              end
              err_acc[a] = int'(acc);
            end
            seg_taken++;
            r.dir_mask      = seg_dirs;
            r.last          = (k == nsub - 1);
            r.segment_done  = (seg_taken >= seg_total);
            r.axis_position = '0;
            if (r.segment_done) seg_active = 1'b0;
            if (keep) due_beats.push_back(r);
          end
        end
      end
      CMD_READ: begin
        r.dir_mask      = seg_dirs;
        r.last          = 1'b1;
        r.segment_done  = !seg_active;
        r.axis_position = (b.axis_select < N_AXES) ? axis_pos[b.axis_select] : '0;
        if (keep) due_beats.push_back(r);
      end
      CMD_ZERO: begin
        for (a = 0; a < N_AXES; a++) axis_pos[a] = '0;
      end
      default: ;
    endcase
  endtask

  // Offers one beat, waits for acceptance, then records what it should produce.
  task automatic issue_cmd(input msd_in_t b, input bit typed, input msd_out_t want);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) begin
      distribute_cmd(b, 1'b0);
      due_beats.push_back(want);
    end else begin
      distribute_cmd(b, 1'b1);
    end
    if (b.cmd <= CMD_ZERO && !(b.cmd == CMD_DELTA && b.axis_select >= N_AXES))
      cmds_done++;
  endtask

  function automatic msd_in_t noise_cmd();
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    return noise[$bits(msd_in_t)-1:0];
  endfunction

  // Loads deltas, starts a segment, then issues random ticks, reads, zeroes and bad commands.
  task automatic run_segment();
    msd_in_t          b;
    logic [STEPS_W-1:0] seg;
    int               a;
    int               pick;
    seg = ($urandom_range(0, 9) == 0) ? STEPS_W'($urandom) : STEPS_W'($urandom_range(0, 80));
    for (a = 0; a < N_AXES; a++) begin
      b = noise_cmd();
      b.cmd = CMD_DELTA;
      if ($urandom_range(0, 7) != 0) b.axis_select = 3'(a);
      if ($urandom_range(0, 5) != 0) b.axis_steps = STEPS_W'($urandom_range(0, seg));
      issue_cmd(b, 1'b0, '0);
    end
    b = noise_cmd();
    b.cmd = CMD_START;
    b.segment_steps = seg;
    issue_cmd(b, 1'b0, '0);
    repeat ($urandom_range(1, 8)) begin
      b = noise_cmd();
      pick = $urandom_range(0, 19);
      if (pick < 14) b.cmd = CMD_TICK;
      else if (pick < 18) b.cmd = CMD_READ;
      else if (pick < 19) b.cmd = CMD_ZERO;
      else b.cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
      issue_cmd(b, 1'b0, '0);
    end
  endtask

  initial begin
    msd_in_t b;
    int      i;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_ROWS; i++)
      issue_cmd(cmd_table[i].beat, cmd_table[i].typed, cmd_table[i].want);

    // drain side holds off while ticks keep coming: the block backs up
    hold_out = 1'b1;
    b = '0;
    b.cmd = CMD_START;
    b.segment_steps = 24'd200;
    b.direction_bits = 6'h2A;
    issue_cmd(b, 1'b0, '0);
    b.cmd = CMD_TICK;
    b.substeps = 5'd16;
    repeat (4) issue_cmd(b, 1'b0, '0);

    cmds_done = 0;
    while (cmds_done < N_RANDOM) begin
      if (cmds_done > N_RANDOM - 60) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) issue_cmd(noise_cmd(), 1'b0, '0);
      else run_segment();
    end
    in_valid <= 1'b0;

    while (due_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0)
      $display("multi_axis_step_distributor_unit test passed");
    else
      $display("multi_axis_step_distributor_unit test failed");
    $finish;
  end

  initial begin : drain_side
    int burst;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_out = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_beats.size() == 0) begin
        $error("result beat with nothing expected: %h", out_beat);
        err_cnt++;
      end else begin
        want_b = due_beats.pop_front();
        if (out_beat.step_mask !== want_b.step_mask) begin
          $error("step_mask: expected %h, got %h", want_b.step_mask, out_beat.step_mask);
          err_cnt++;
        end
        if (out_beat.dir_mask !== want_b.dir_mask) begin
          $error("dir_mask: expected %h, got %h", want_b.dir_mask, out_beat.dir_mask);
          err_cnt++;
        end
        if (out_beat.last !== want_b.last) begin
          $error("last: expected %b, got %b", want_b.last, out_beat.last);
          err_cnt++;
        end
        if (out_beat.segment_done !== want_b.segment_done) begin
          $error("segment_done: expected %b, got %b", want_b.segment_done,
                 out_beat.segment_done);
          err_cnt++;
        end
        if (out_beat.axis_position !== want_b.axis_position) begin
          $error("axis_position: expected %0d, got %0d", want_b.axis_position,
                 out_beat.axis_position);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("multi_axis_step_distributor_unit test failed");
    $finish;
  end

endmodule

[multi_axis_step_distributor_unit.f]
rtl/msd_pkg.sv
rtl/msd_axis_lane.sv
rtl/multi_axis_step_distributor_unit.sv
sim/multi_axis_step_distributor_unit_tb.sv
